/* design/scm_pkg.sv */
package scm_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 8;

    localparam int RowW  = $clog2(MAX_ROWS);
    localparam int CntW  = $clog2(MAX_ROWS + 1);
    localparam int ColW  = $clog2(MAX_COLS);
    localparam int AddrW = RowW + ColW;
    localparam int CcW   = 4;

    localparam int SampW = 24;
    localparam int DevW  = SampW + 1;
    localparam int ProdW = 2 * DevW;
    localparam int AccW  = 64;
    localparam int CovW  = 50;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [AddrW-1:0]  wr_addr;
        logic              rd_en;
        logic [RowW-1:0]   rd_row;
        logic [ColW-1:0]   col_a;
        logic [ColW-1:0]   col_b;
        logic              mean_mode;
        logic              acc_clr;
        logic              div_start;
        logic [CntW-1:0]   divisor;
        logic              mean_we;
        logic              lat_a;
        logic              lat_b;
        logic              out_load;
        logic              out_empty;
        logic [ColW-1:0]   out_row;
        logic [ColW-1:0]   out_col;
        logic [1:0]        out_status;
        logic              out_last;
    } scm_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
    } scm_stat_t;

endpackage

/* design/sample_covariance_matrix_top.sv */
// Population covariance matrix of a streamed data matrix. Elements (Q8.16)
// arrive row-major, one request per cycle while loading; is_last ends the
// data set and a trailing partial row is ignored. Up to 256 full rows are
// kept; rows past that are dropped and every result of the run reports
// status 2. After is_last the block stalls its input and computes: per
// column one read pass over the n stored rows, a pipeline drain and a
// bit-serial division for the mean; then per matrix entry a mean select
// for each of its two columns, a read pass over the n rows, a drain, a
// bit-serial division and a load of the output register, which waits
// while the receiver stalls. Results come out row-major (C*C entries for
// C columns, last one flagged) through an output register; with no
// complete rows a single status-1 result with value 0 is given.
// column_count (APB offset 0) is to be written only while idle; keeping to
// this is up to the user, as the block itself has no check for it. 0 acts
// as 1, values above 8 act as 8, and a write drops any partial row in
// progress.
module sample_covariance_matrix_top
    import scm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [SampW-1:0] sample_value,
    input  logic                    is_last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [CovW-1:0]  cov_value,
    output logic [ColW-1:0]         row_index,
    output logic [ColW-1:0]         col_index,
    output logic [1:0]              status,
    output logic                    last_entry
);

    logic [CcW-1:0] col_count_reg;
    logic [CcW-1:0] eff_cols;
    logic           cfg_wr;
    scm_cmd_t       cmd;
    scm_stat_t      stat;

    // single register; every offset decodes to column_count
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00);
    assign prdata = {{(32-CcW){1'b0}}, col_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_count_reg <= CcW'(4);
        else if (cfg_wr)
            col_count_reg <= pwdata[CcW-1:0];
    end

    // clamp to 1..MAX_COLS
    always_comb
    begin
        if (col_count_reg == '0)
            eff_cols = CcW'(1);
        else if (col_count_reg > CcW'(MAX_COLS))
            eff_cols = CcW'(MAX_COLS);
        else
            eff_cols = col_count_reg;
    end

    scm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_cols  (eff_cols),
        .cfg_wr    (cfg_wr),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    scm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_value (sample_value),
        .stat         (stat),
        .cov_value    (cov_value),
        .row_index    (row_index),
        .col_index    (col_index),
        .status       (status),
        .last_entry   (last_entry)
    );

endmodule

/* design/scm_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module scm_div
    import scm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [AccW-1:0] dividend,
    input  logic [CntW-1:0]        divisor,
    output logic signed [AccW-1:0] quotient,
    output logic                   done
);

    localparam int CntBits = $clog2(AccW);

    logic [AccW-1:0]    q_reg;
    logic [CntW:0]      r_reg;
    logic [CntBits-1:0] cnt_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic               neg_reg;
    logic               done_reg;
    logic [AccW-1:0]    res_reg;
    logic [CntW:0]      trial;
    logic               fits;

    assign trial = {r_reg[CntW-1:0], q_reg[AccW-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntBits'(AccW - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[AccW-1] ? AccW'(-dividend) : dividend;
            r_reg   <= '0;
            neg_reg <= dividend[AccW-1];
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[AccW-2:0], fits};
            r_reg <= fits ? (trial - {1'b0, divisor}) : trial;
        end
        if (fin_reg)
            res_reg <= neg_reg ? AccW'(-q_reg) : q_reg;
    end

    assign quotient = res_reg;
    assign done     = done_reg;

endmodule

/* design/scm_dp.sv */
// Sample store, deviation/product pipeline, accumulator, means, result register.
module scm_dp
    import scm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  scm_cmd_t                cmd,
    input  logic signed [SampW-1:0] sample_value,
    output scm_stat_t               stat,
    output logic signed [CovW-1:0]  cov_value,
    output logic [ColW-1:0]         row_index,
    output logic [ColW-1:0]         col_index,
    output logic [1:0]              status,
    output logic                    last_entry
);

    logic [SampW-1:0]        mem [2**AddrW];
    logic signed [SampW-1:0] qa_reg, qb_reg;
    logic signed [SampW-1:0] means_reg [MAX_COLS];
    logic signed [SampW-1:0] mean_a_reg, mean_b_reg;
    logic signed [DevW-1:0]  da_reg, db_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [AccW-1:0]  acc_reg;
    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [AccW-1:0]  quot;
    logic                    div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= sample_value;
        qa_reg <= mem[{cmd.rd_row, cmd.col_a}];
        qb_reg <= mem[{cmd.rd_row, cmd.col_b}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // mean pass sums raw samples (times one)
        if (cmd.mean_mode)
        begin
            da_reg <= {qa_reg[SampW-1], qa_reg};
            db_reg <= DevW'(1);
        end
        else
        begin
            da_reg <= {qa_reg[SampW-1], qa_reg} - {mean_a_reg[SampW-1], mean_a_reg};
            db_reg <= {qb_reg[SampW-1], qb_reg} - {mean_b_reg[SampW-1], mean_b_reg};
        end
        prod_reg <= da_reg * db_reg;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_reg + {{(AccW-ProdW){prod_reg[ProdW-1]}}, prod_reg};
        if (cmd.mean_we)
            means_reg[cmd.col_a] <= quot[SampW-1:0];
        if (cmd.lat_a)
            mean_a_reg <= means_reg[cmd.col_a];
        if (cmd.lat_b)
            mean_b_reg <= means_reg[cmd.col_a];
        if (cmd.out_load)
        begin
            cov_value  <= cmd.out_empty ? '0 : quot[CovW-1:0];
            row_index  <= cmd.out_row;
            col_index  <= cmd.out_col;
            status     <= cmd.out_status;
            last_entry <= cmd.out_last;
        end
    end

    scm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (cmd.divisor),
        .quotient (quot),
        .done     (div_done)
    );

    assign stat.pipe_busy = v1_reg | v2_reg | v3_reg;
    assign stat.div_done  = div_done;

endmodule

/* design/scm_ctrl.sv */
// Load counters and compute sequencer.
module scm_ctrl
    import scm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CcW-1:0]  eff_cols,
    input  logic            cfg_wr,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            is_last,
    output logic            out_valid,
    input  logic            out_stall,
    input  scm_stat_t       stat,
    output scm_cmd_t        cmd
);

    typedef enum logic [10:0] {
        S_LOAD   = 11'b00000000001,
        S_M_RUN  = 11'b00000000010,
        S_M_WAIT = 11'b00000000100,
        S_M_DIV  = 11'b00000001000,
        S_P_SELA = 11'b00000010000,
        S_P_SELB = 11'b00000100000,
        S_P_RUN  = 11'b00001000000,
        S_P_WAIT = 11'b00010000000,
        S_P_DIV  = 11'b00100000000,
        S_EMIT   = 11'b01000000000,
        S_EMPTY  = 11'b10000000000
    } scm_state_t;

    scm_state_t      state_reg, state_next;
    logic [CntW-1:0] rows_reg, rows_next;
    logic [ColW-1:0] colpos_reg, colpos_next;
    logic            ovf_reg, ovf_next;
    logic [RowW-1:0] s_reg, s_next;
    logic [ColW-1:0] i_reg, i_next;
    logic [ColW-1:0] j_reg, j_next;
    logic            ov_reg, ov_next;

    logic            accept;
    logic            row_done;
    logic            has_room;
    logic [CntW-1:0] n_after;
    logic [ColW-1:0] last_col;
    logic            s_last;
    logic            out_free;
    logic            last_pair;

    assign last_col  = eff_cols[ColW-1:0] - 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_LOAD);
    assign row_done  = (colpos_reg == last_col);
    assign has_room  = (rows_reg != CntW'(MAX_ROWS));
    assign n_after   = rows_reg + CntW'(row_done && has_room);
    assign s_last    = ({1'b0, s_reg} == rows_reg - 1'b1);
    assign out_free  = !ov_reg || !out_stall;
    assign last_pair = (i_reg == last_col) && (j_reg == last_col);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next  = state_reg;
        rows_next   = rows_reg;
        colpos_next = colpos_reg;
        ovf_next    = ovf_reg;
        s_next      = s_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        ov_next     = ov_reg && out_stall;

        cmd            = '0;
        cmd.wr_addr    = {rows_reg[RowW-1:0], colpos_reg};
        cmd.rd_row     = s_reg;
        cmd.divisor    = rows_reg;
        cmd.out_row    = i_reg;
        cmd.out_col    = j_reg;
        cmd.out_status = ovf_reg ? ST_OVERFLOW : ST_OK;
        cmd.out_last   = last_pair;

        case (state_reg)
            S_LOAD:
            begin
                cmd.acc_clr = 1'b1;
                if (accept)
                begin
                    cmd.wr_en   = has_room;
                    colpos_next = row_done ? '0 : colpos_reg + 1'b1;
                    rows_next   = n_after;
                    ovf_next    = ovf_reg || (row_done && !has_room);
                    if (is_last)
                    begin
                        s_next = '0;
                        j_next = '0;
                        state_next = (n_after == '0) ? S_EMPTY : S_M_RUN;
                    end
                end
            end
            S_M_RUN:
            begin
                cmd.rd_en     = 1'b1;
                cmd.mean_mode = 1'b1;
                cmd.col_a     = j_reg;
                s_next        = s_reg + 1'b1;
                if (s_last)
                    state_next = S_M_WAIT;
            end
            S_M_WAIT:
            begin
                cmd.mean_mode = 1'b1;
                if (!stat.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    cmd.acc_clr   = 1'b1;
                    state_next    = S_M_DIV;
                end
            end
            S_M_DIV:
            begin
                cmd.col_a = j_reg;
                if (stat.div_done)
                begin
                    cmd.mean_we = 1'b1;
                    s_next      = '0;
                    if (j_reg == last_col)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_P_SELA;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_M_RUN;
                    end
                end
            end
            S_P_SELA:
            begin
                cmd.col_a  = i_reg;
                cmd.lat_a  = 1'b1;
                state_next = S_P_SELB;
            end
            S_P_SELB:
            begin
                cmd.col_a  = j_reg;
                cmd.lat_b  = 1'b1;
                s_next     = '0;
                state_next = S_P_RUN;
            end
            S_P_RUN:
            begin
                cmd.rd_en = 1'b1;
                cmd.col_a = i_reg;
                cmd.col_b = j_reg;
                s_next    = s_reg + 1'b1;
                if (s_last)
                    state_next = S_P_WAIT;
            end
            S_P_WAIT:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    cmd.acc_clr   = 1'b1;
                    state_next    = S_P_DIV;
                end
            end
            S_P_DIV:
            begin
                if (stat.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    if (last_pair)
                    begin
                        rows_next   = '0;
                        colpos_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        if (j_reg == last_col)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                            j_next = j_reg + 1'b1;
                        state_next = S_P_SELA;
                    end
                end
            end
            S_EMPTY:
            begin
                cmd.out_empty  = 1'b1;
                cmd.out_row    = '0;
                cmd.out_col    = '0;
                cmd.out_status = ST_EMPTY;
                cmd.out_last   = 1'b1;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    rows_next    = '0;
                    colpos_next  = '0;
                    ovf_next     = 1'b0;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (cfg_wr)
            colpos_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            rows_reg   <= '0;
            colpos_reg <= '0;
            ovf_reg    <= 1'b0;
            s_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rows_reg   <= rows_next;
            colpos_reg <= colpos_next;
            ovf_reg    <= ovf_next;
            s_reg      <= s_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            ov_reg     <= ov_next;
        end
    end

endmodule
